// ===== rtl/psas_pkg.sv =====
package psas_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int BASE_W      = 2;
  localparam int SCORE_W     = 9;
  localparam int SHIFT_W     = 7;
  localparam int POS_SHIFT_W = 6;
  localparam int LEN_W       = 7;
  localparam int WGT_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SELF_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LIMIT  = 1'b1;

  localparam logic [SCORE_W-1:0] SELF_LIMIT_RST = 9'd20;
  localparam logic [SCORE_W-1:0] END_LIMIT_RST  = 9'd10;

  localparam logic [BASE_W-1:0] BASE_A = 2'd0;
  localparam logic [BASE_W-1:0] BASE_T = 2'd1;
  localparam logic [BASE_W-1:0] BASE_G = 2'd2;
  localparam logic [BASE_W-1:0] BASE_C = 2'd3;

  localparam logic [WGT_W-1:0] WGT_AT = 3'd2;
  localparam logic [WGT_W-1:0] WGT_GC = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic setup;
    logic rd;
    logic acc;
    logic upd;
    logic capture;
  } psas_cmd_t;

  typedef struct packed {
    logic pairs_zero;
    logic last_pair;
    logic last_stretch;
    logic out_busy;
  } psas_sts_t;

  function automatic logic [WGT_W-1:0] pair_weight(logic [BASE_W-1:0] a,
                                                   logic [BASE_W-1:0] b);
    logic [WGT_W-1:0] w;
    w = '0;
    if ((a == BASE_A && b == BASE_T) || (a == BASE_T && b == BASE_A)) w = WGT_AT;
    if ((a == BASE_G && b == BASE_C) || (a == BASE_C && b == BASE_G)) w = WGT_GC;
    return w;
  endfunction

endpackage

// ===== rtl/psas_in_if.sv =====
interface psas_in_if import psas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic              last_base;

  modport source (output valid, output base, output last_base, input ready);
  modport sink   (input valid, input base, input last_base, output ready);
endinterface

// ===== rtl/psas_out_if.sv =====
interface psas_out_if import psas_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SCORE_W-1:0]     self_score;
  logic [SHIFT_W-1:0]     self_shift;
  logic [SCORE_W-1:0]     end_score_pos;
  logic [POS_SHIFT_W-1:0] end_shift_pos;
  logic [SCORE_W-1:0]     end_score_neg;
  logic [SHIFT_W-1:0]     end_shift_neg;
  logic                   self_ok;
  logic                   end_ok;
  logic [LEN_W-1:0]       primer_length;
  logic                   too_long;

  modport source (output valid, output self_score, output self_shift,
                  output end_score_pos, output end_shift_pos, output end_score_neg,
                  output end_shift_neg, output self_ok, output end_ok,
                  output primer_length, output too_long, input ready);
  modport sink   (input valid, input self_score, input self_shift,
                  input end_score_pos, input end_shift_pos, input end_score_neg,
                  input end_shift_neg, input self_ok, input end_ok,
                  input primer_length, input too_long, output ready);
endinterface

// ===== rtl/psas_ctrl.sv =====
module psas_ctrl import psas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  psas_sts_t sts,
  output psas_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD, S_SETUP, S_READ, S_ACC, S_UPD, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.pairs_zero ? S_UPD : S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_pair ? S_UPD : S_READ;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last_stretch ? S_DONE : S_SETUP;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/psas_datapath.sv =====
module psas_datapath import psas_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psas_cmd_t            cmd,
  output psas_sts_t            sts,
  input  logic [BASE_W-1:0]    in_base,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  psas_out_if.source           out_if
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [BASE_W-1:0] mem [MAX_LEN];

  logic [CW-1:0]          cnt_r;
  logic                   ovf_r;
  logic [SCORE_W-1:0]     self_lim_r, end_lim_r;
  logic                   suf_r;
  logic [AW-1:0]          start_r;
  logic [CW-1:0]          len_r;
  logic [AW-1:0]          p_r, q_r;
  logic [CW-1:0]          pairs_r;
  logic                   core_r;
  logic [BASE_W-1:0]      rd_a_r, rd_b_r;
  logic [SCORE_W-1:0]     val_r, fold_r;
  logic                   full_r;
  logic [SCORE_W-1:0]     best_self_r, best_pos_r, best_neg_r;
  logic [SHIFT_W-1:0]     self_shift_r, neg_shift_r;
  logic [AW-1:0]          pos_shift_r;
  logic                   out_valid_r;
  logic [SCORE_W-1:0]     o_self_r, o_pos_r, o_neg_r;
  logic [SHIFT_W-1:0]     o_self_shift_r, o_neg_shift_r;
  logic [POS_SHIFT_W-1:0] o_pos_shift_r;
  logic                   o_self_ok_r, o_end_ok_r, o_too_long_r;
  logic [LEN_W-1:0]       o_len_r;

  logic [CW-1:0]      half;
  logic [CW:0]        mid;
  logic [CW:0]        p_init, q_init;
  logic [WGT_W-1:0]   w;
  logic [SCORE_W-1:0] w2;
  logic               nf;
  logic [SHIFT_W-1:0] k_cur;
  logic               first_pre, whole;

  assign half   = len_r >> 1;
  assign mid    = (CW+1)'(start_r) + (CW+1)'(half);
  assign p_init = mid - (CW+1)'(1);
  assign q_init = len_r[0] ? mid + (CW+1)'(1) : mid;
  assign w      = pair_weight(rd_a_r, rd_b_r);
  assign w2     = SCORE_W'({w, 1'b0});
  assign nf     = (val_r != '0) && (w != '0) && full_r;
  assign k_cur  = suf_r ? SHIFT_W'(start_r) : SHIFT_W'(len_r) - SHIFT_W'(cnt_r);
  assign first_pre = !suf_r && (len_r == CW'(1));
  assign whole     = !suf_r && (len_r == cnt_r);

  assign sts.pairs_zero   = (half == '0);
  assign sts.last_pair    = (pairs_r == CW'(1));
  assign sts.last_stretch = (whole && cnt_r == CW'(1)) ||
                            (suf_r && CW'(start_r) == cnt_r - CW'(1));
  assign sts.out_busy     = out_valid_r && !out_if.ready;

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < CW'(MAX_LEN)) begin
      mem[cnt_r[AW-1:0]] <= in_base;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[p_r];
      rd_b_r <= mem[q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      self_lim_r  <= SELF_LIMIT_RST;
      end_lim_r   <= END_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SELF_LIMIT: self_lim_r <= cfg_wdata;
          CFG_END_LIMIT:  end_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (cnt_r < CW'(MAX_LEN)) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.capture) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      suf_r   <= 1'b0;
      start_r <= '0;
      len_r   <= CW'(1);
    end
    if (cmd.setup) begin
      p_r     <= p_init[AW-1:0];
      q_r     <= q_init[AW-1:0];
      pairs_r <= half;
      core_r  <= !len_r[0];
      val_r   <= '0;
      full_r  <= 1'b1;
      fold_r  <= '0;
    end
    if (cmd.acc) begin
      p_r     <= p_r - AW'(1);
      q_r     <= q_r + AW'(1);
      pairs_r <= pairs_r - CW'(1);
      core_r  <= 1'b0;
      fold_r  <= fold_r + w2;
      if (core_r) begin
        val_r  <= w2;
        full_r <= (w != '0);
      end else begin
        full_r <= nf;
        if (nf) begin
          val_r <= val_r + w2;
        end else if (w != '0) begin
          val_r <= val_r + SCORE_W'(w);
        end else begin
          val_r <= '0;
        end
      end
    end
    if (cmd.upd) begin
      if (first_pre || fold_r > best_self_r) begin
        best_self_r  <= fold_r;
        self_shift_r <= k_cur;
      end
      if (!suf_r && (first_pre || val_r > best_neg_r)) begin
        best_neg_r  <= val_r;
        neg_shift_r <= k_cur;
      end
      if (whole || (suf_r && val_r > best_pos_r)) begin
        best_pos_r  <= val_r;
        pos_shift_r <= suf_r ? start_r : '0;
      end
      if (!suf_r && !whole) begin
        len_r <= len_r + CW'(1);
      end else if (whole) begin
        suf_r   <= 1'b1;
        start_r <= AW'(1);
        len_r   <= len_r - CW'(1);
      end else begin
        start_r <= start_r + AW'(1);
        len_r   <= len_r - CW'(1);
      end
    end
    if (cmd.capture) begin
      o_self_r       <= best_self_r;
      o_self_shift_r <= self_shift_r;
      o_pos_r        <= best_pos_r;
      o_pos_shift_r  <= POS_SHIFT_W'(pos_shift_r);
      o_neg_r        <= best_neg_r;
      o_neg_shift_r  <= neg_shift_r;
      o_self_ok_r    <= (best_self_r <= self_lim_r);
      o_end_ok_r     <= (best_pos_r <= end_lim_r) && (best_neg_r <= end_lim_r);
      o_len_r        <= LEN_W'(cnt_r);
      o_too_long_r   <= ovf_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.self_score    = o_self_r;
  assign out_if.self_shift    = o_self_shift_r;
  assign out_if.end_score_pos = o_pos_r;
  assign out_if.end_shift_pos = o_pos_shift_r;
  assign out_if.end_score_neg = o_neg_r;
  assign out_if.end_shift_neg = o_neg_shift_r;
  assign out_if.self_ok       = o_self_ok_r;
  assign out_if.end_ok        = o_end_ok_r;
  assign out_if.primer_length = o_len_r;
  assign out_if.too_long      = o_too_long_r;

endmodule

// ===== rtl/primer_self_annealing_scorer_top.sv =====
// channel  | dir | handshake          | payload
// in_if    | in  | valid/ready        | base, last_base
// out_if   | out | valid/ready        | scores, shifts, ok flags, length, too_long
// cfg      | in  | cfg_we             | cfg_index, cfg_wdata
//
// Bases load one per cycle while loading. After the last base, scoring walks
// every prefix and suffix of the n stored bases: per stretch a setup and an
// update step, per base pair a two-port base store read and an accumulate step.
// No base is taken while scoring runs; the result register holds until taken.
// Reset is synchronous, active low, clears counts and flags and reloads limits.
module primer_self_annealing_scorer_top import psas_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psas_in_if.sink              in_if,
  psas_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  psas_cmd_t cmd;
  psas_sts_t sts;

  psas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last_base),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psas_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_base   (in_if.base),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_if    (out_if)
  );

endmodule
